// ----- design/kofe_pkg.sv -----
// package for the keyed oldest-first event cache
// types, sizes and codes shared by the cell chain, the controller and the top level
// no dependencies

package kofe_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int DATA_W = 64;
    localparam int AGE_W  = 64;
    localparam int ADDR_W = 3;
    localparam int REG_W  = 32;

    // register index as taken from paddr above the byte offset
    localparam logic [ADDR_W-3:0] REG_NO_LISTENER = '0;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_POP,
        OP_INIT,
        OP_SHUTDOWN
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED,
        ST_POPPED,
        ST_NOMATCH,
        ST_FULL,
        ST_REJECTED,
        ST_CLEARED,
        ST_NOTREADY
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    // token that walks down the cell chain, one cell per cycle
    typedef struct packed {
        logic              active;
        logic              is_pop;
        logic [KEY_W-1:0]  owner;
        logic [KEY_W-1:0]  listener;
        logic [DATA_W-1:0] payload;  // insert: data to store, pop: best payload so far
        logic [AGE_W-1:0]  age;      // insert: stamp to store, pop: best age so far
        logic              found;
        logic [IDX_W-1:0]  idx;
    } tok_t;

    // broadcast commands from the controller to every cell
    typedef struct packed {
        logic             clear;
        logic             remove;
        logic [IDX_W-1:0] idx;
    } cmd_t;

endpackage

// ----- design/kofe_cell.sv -----
// one slot of the event cache chain: holds an entry and passes the scan token on
// depends on kofe_pkg

module kofe_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [kofe_pkg::IDX_W-1:0]  cell_idx,
    input  kofe_pkg::cmd_t              cmd,
    input  kofe_pkg::tok_t              tok_in,
    output kofe_pkg::tok_t              tok_out
);
    import kofe_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [KEY_W-1:0]  owner_reg;
    logic [KEY_W-1:0]  listener_reg;
    logic [DATA_W-1:0] payload_reg;
    logic [AGE_W-1:0]  age_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic              hit_free;
    logic              match;
    logic              better;

    always_comb
    begin
        hit_free = tok_in.active && !tok_in.is_pop && !tok_in.found && !valid_reg;
        match    = tok_in.active && tok_in.is_pop && valid_reg &&
                   (owner_reg == tok_in.owner) && (listener_reg == tok_in.listener);
        // strict compare keeps the lower slot on equal ages
        better   = match && (!tok_in.found || (age_reg < tok_in.age));

        tok_next = tok_in;
        if (hit_free)
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = cell_idx;
        end
        if (better)
        begin
            tok_next.found   = 1'b1;
            tok_next.idx     = cell_idx;
            tok_next.age     = age_reg;
            tok_next.payload = payload_reg;
        end

        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.remove && (cmd.idx == cell_idx))
        begin
            valid_next = 1'b0;
        end
        else if (hit_free)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_free)
        begin
            owner_reg    <= tok_in.owner;
            listener_reg <= tok_in.listener;
            payload_reg  <= tok_in.payload;
            age_reg      <= tok_in.age;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- design/kofe_ctrl.sv -----
// controller of the event cache: command decode, scan sequencing, counters, result registers
// depends on kofe_pkg

module kofe_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [1:0]                   opcode,
    input  logic [kofe_pkg::KEY_W-1:0]   owner_key,
    input  logic [kofe_pkg::KEY_W-1:0]   listener_key,
    input  logic [kofe_pkg::DATA_W-1:0]  event_payload,
    input  logic [kofe_pkg::KEY_W-1:0]   no_listener,
    input  kofe_pkg::tok_t               tail,
    output kofe_pkg::tok_t               head,
    output kofe_pkg::cmd_t               cmd,
    output logic                         busy,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [kofe_pkg::DATA_W-1:0]  popped_payload,
    output logic [kofe_pkg::CNT_W-1:0]   occupancy
);
    import kofe_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic              ready_reg;
    logic              ready_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [AGE_W-1:0]  age_reg;
    logic [AGE_W-1:0]  age_next;
    logic              done_reg;
    logic              done_next;
    status_t           status_reg;
    status_t           status_next;
    logic [DATA_W-1:0] pop_data_reg;
    logic [DATA_W-1:0] pop_data_next;
    logic [CNT_W-1:0]  occ_reg;
    logic [CNT_W-1:0]  occ_next;
    logic              accept;
    logic              need_scan;
    op_t               op;

    assign op     = op_t'(opcode);
    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        need_scan = 1'b0;
        unique case (op)
            OP_INSERT:
            begin
                need_scan = ready_reg && (count_reg < CNT_W'(DEPTH));
            end
            OP_POP:
            begin
                need_scan = ready_reg && (listener_key != no_listener);
            end
            default:
            begin
                need_scan = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && need_scan)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tail.active)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        head          = '0;
        cmd           = '0;
        ready_next    = ready_reg;
        count_next    = count_reg;
        age_next      = age_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        pop_data_next = '0;
        occ_next      = occ_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (need_scan)
                    begin
                        head.active   = 1'b1;
                        head.is_pop   = (op == OP_POP);
                        head.owner    = owner_key;
                        head.listener = listener_key;
                        if (op == OP_INSERT)
                        begin
                            head.payload = event_payload;
                            head.age     = age_reg + AGE_W'(1);
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                        unique case (op)
                            OP_INSERT:
                            begin
                                status_next = ready_reg ? ST_FULL : ST_NOTREADY;
                                occ_next    = ready_reg ? count_reg : '0;
                            end
                            OP_POP:
                            begin
                                status_next = ST_REJECTED;
                                occ_next    = ready_reg ? count_reg : '0;
                            end
                            default:
                            begin
                                cmd.clear   = 1'b1;
                                ready_next  = (op == OP_INIT);
                                count_next  = '0;
                                age_next    = '0;
                                status_next = ST_CLEARED;
                                occ_next    = '0;
                            end
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                if (tail.active)
                begin
                    done_next = 1'b1;
                    if (!tail.is_pop)
                    begin
                        status_next = ST_INSERTED;
                        count_next  = count_reg + CNT_W'(1);
                        occ_next    = count_reg + CNT_W'(1);
                        // sequence skips zero after it wraps
                        age_next    = (tail.age == '0) ? AGE_W'(1) : tail.age;
                    end
                    else if (tail.found)
                    begin
                        status_next   = ST_POPPED;
                        pop_data_next = tail.payload;
                        cmd.remove    = 1'b1;
                        cmd.idx       = tail.idx;
                        count_next    = count_reg - CNT_W'(1);
                        occ_next      = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_NOMATCH;
                        occ_next    = count_reg;
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ready_reg  <= 1'b0;
            count_reg  <= '0;
            age_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            ready_reg  <= ready_next;
            count_reg  <= count_next;
            age_reg    <= age_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_data_reg <= pop_data_next;
        occ_reg      <= occ_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = status_reg;
    assign popped_payload = pop_data_reg;
    assign occupancy      = occ_reg;

endmodule

// ----- design/keyed_oldest_first_event_cache_unit.sv -----
// top level of the keyed oldest-first event cache: register port, controller, chain of slot cells
// depends on kofe_pkg, kofe_cell, kofe_ctrl
//
// channel   | handshake                   | payload
// ----------+-----------------------------+------------------------------------------------
// command   | start, busy (in when !busy) | opcode, owner_key, listener_key, event_payload
// result    | done (one-cycle strobe)     | status, popped_payload, occupancy
// registers | psel, penable, pwrite, ...  | paddr, pwdata, prdata (no_listener_value)
//
// init, shutdown and commands refused up front finish in one cycle: result strobe follows
// the transfer, and busy stays low.
// insert and pop send a token down the DEPTH-cell chain, one cell a cycle: busy for DEPTH
// cycles (16), result in the cycle after, a new command may be taken in that same cycle.
// reset clears the table valid bits, counters and ready flag at once; no clearing pass.
// the result receiver cannot stall; each result is shown for exactly one cycle.

module keyed_oldest_first_event_cache_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   opcode,
    input  logic [kofe_pkg::KEY_W-1:0]   owner_key,
    input  logic [kofe_pkg::KEY_W-1:0]   listener_key,
    input  logic [kofe_pkg::DATA_W-1:0]  event_payload,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [kofe_pkg::DATA_W-1:0]  popped_payload,
    output logic [kofe_pkg::CNT_W-1:0]   occupancy,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kofe_pkg::ADDR_W-1:0]  paddr,
    input  logic [kofe_pkg::REG_W-1:0]   pwdata,
    output logic [kofe_pkg::REG_W-1:0]   prdata,
    output logic                         pready
);
    import kofe_pkg::*;

    logic [KEY_W-1:0] no_lis_reg;
    logic             reg_hit;
    tok_t             chain [0:DEPTH];
    cmd_t             cmd;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_NO_LISTENER);
    assign prdata  = reg_hit ? no_lis_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_lis_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            no_lis_reg <= pwdata;
        end
    end

    kofe_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .opcode         (opcode),
        .owner_key      (owner_key),
        .listener_key   (listener_key),
        .event_payload  (event_payload),
        .no_listener    (no_lis_reg),
        .tail           (chain[DEPTH]),
        .head           (chain[0]),
        .cmd            (cmd),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .popped_payload (popped_payload),
        .occupancy      (occupancy)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        kofe_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .cmd      (cmd),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

endmodule

// ----- design/kofe_checker.sv -----
// port-level checks for the keyed oldest-first event cache, bound to the top level
// depends on kofe_pkg and keyed_oldest_first_event_cache_unit

module kofe_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   opcode,
    input logic                         done,
    input logic [2:0]                   status,
    input logic [kofe_pkg::DATA_W-1:0]  popped_payload,
    input logic [kofe_pkg::CNT_W-1:0]   occupancy
);
    import kofe_pkg::*;

    // payload is only carried by a successful pop
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_POPPED) |-> popped_payload == '0)
        else $error("popped_payload nonzero without a pop");

    // init and shutdown answer in the next cycle with an empty table
    a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && ((opcode == OP_INIT) || (opcode == OP_SHUTDOWN))
        |=> done && (status == ST_CLEARED) && (occupancy == '0))
        else $error("clear did not complete in one cycle");

    // not ready always reports zero occupancy
    a_notready_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_NOTREADY) |-> occupancy == '0)
        else $error("occupancy nonzero while not ready");

    // an accepted pop either scans or answers at once
    a_pop_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (opcode == OP_POP) |=> busy || done)
        else $error("pop accepted but neither scanning nor answered");

    // a result never arrives while a scan is still running
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy && $past(busy) && $past(done) |-> 1'b0)
        else $error("result strobe during a scan");

endmodule

bind keyed_oldest_first_event_cache_unit kofe_checker u_kofe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .done           (done),
    .status         (status),
    .popped_payload (popped_payload),
    .occupancy      (occupancy)
);

// ----- verif/keyed_oldest_first_event_cache_unit_tb.sv -----
// testbench for the keyed oldest-first event cache: directed then random commands,
// each result checked against an in-bench model of the slot table
// depends on kofe_pkg and keyed_oldest_first_event_cache_unit
`timescale 1ns / 1ps

module keyed_oldest_first_event_cache_unit_tb;

    import kofe_pkg::*;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int PHASES         = 5;
    localparam int PER_PHASE      = RANDOM_ITEMS / (PHASES - 1);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        op_t               op;
        logic [KEY_W-1:0]  owner;
        logic [KEY_W-1:0]  listener;
        logic [DATA_W-1:0] payload;
    } cache_cmd_t;

    typedef struct {
        status_t           st;
        logic [DATA_W-1:0] payload;
        logic [CNT_W-1:0]  occ;
    } cache_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          opcode = '0;
    logic [KEY_W-1:0]    owner_key = '0;
    logic [KEY_W-1:0]    listener_key = '0;
    logic [DATA_W-1:0]   event_payload = '0;
    logic                done;
    logic [2:0]          status;
    logic [DATA_W-1:0]   popped_payload;
    logic [CNT_W-1:0]    occupancy;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [REG_W-1:0]    pwdata = '0;
    logic [REG_W-1:0]    prdata;
    logic                pready;

    // commands waiting for the driver, results waiting for the monitor
    cache_cmd_t          cmd_q[$];
    cache_result_t       result_q[$];
    cache_cmd_t          cur_cmd;
    int                  idle_left = 0;
    bit                  gaps_on = 1'b1;
    int                  errors = 0;
    int                  stall_cycles = 0;

    // model of the slot table
    logic                tbl_valid[DEPTH];
    logic [KEY_W-1:0]    tbl_owner[DEPTH];
    logic [KEY_W-1:0]    tbl_listener[DEPTH];
    logic [DATA_W-1:0]   tbl_payload[DEPTH];
    logic [AGE_W-1:0]    tbl_age[DEPTH];
    logic [AGE_W-1:0]    age_count;
    logic [CNT_W-1:0]    fill_count;
    logic                is_ready;
    logic [REG_W-1:0]    none_listener;

    keyed_oldest_first_event_cache_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .owner_key      (owner_key),
        .listener_key   (listener_key),
        .event_payload  (event_payload),
        .done           (done),
        .status         (status),
        .popped_payload (popped_payload),
        .occupancy      (occupancy),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 clk = ~clk;

    function automatic void clear_table();
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
        end
        age_count  = '0;
        fill_count = '0;
    endfunction

    function automatic cache_result_t predict_cache_result(cache_cmd_t c);
        cache_result_t    r;
        int               best;
        logic [AGE_W-1:0] best_age;
        bit               placed;
        r.payload = '0;
        r.st      = ST_CLEARED;
        best      = -1;
        best_age  = '0;
        placed    = 1'b0;
        case (c.op)
            OP_INSERT:
            begin
                if (!is_ready)
                    r.st = ST_NOTREADY;
                else
                begin
                    if (fill_count < DEPTH)
                    begin
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            if (!placed && !tbl_valid[i])
                            begin
                                // the stamp may be zero on wrap; the counter then skips zero
                                age_count = age_count + 1'b1;
                                tbl_age[i] = age_count;
                                if (age_count == '0)
                                    age_count = AGE_W'(1);
                                tbl_owner[i]    = c.owner;
                                tbl_listener[i] = c.listener;
                                tbl_payload[i]  = c.payload;
                                tbl_valid[i]    = 1'b1;
                                fill_count      = fill_count + 1'b1;
                                placed          = 1'b1;
                            end
                        end
                    end
                    r.st = placed ? ST_INSERTED : ST_FULL;
                end
            end
            OP_POP:
            begin
                if (!is_ready || c.listener == none_listener)
                    r.st = ST_REJECTED;
                else
                begin
                    // strict compare keeps the lower slot on equal ages
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (tbl_valid[i] && tbl_owner[i] == c.owner &&
                            tbl_listener[i] == c.listener &&
                            (best < 0 || tbl_age[i] < best_age))
                        begin
                            best     = i;
                            best_age = tbl_age[i];
                        end
                    end
                    if (best < 0)
                        r.st = ST_NOMATCH;
                    else
                    begin
                        r.st            = ST_POPPED;
                        r.payload       = tbl_payload[best];
                        tbl_valid[best] = 1'b0;
                        if (fill_count > 0)
                            fill_count = fill_count - 1'b1;
                    end
                end
            end
            default:
            begin
                clear_table();
                is_ready = (c.op == OP_INIT);
                r.st     = ST_CLEARED;
            end
        endcase
        r.occ = is_ready ? fill_count : '0;
        return r;
    endfunction

    function automatic cache_cmd_t mk_cmd(op_t op, logic [KEY_W-1:0] owner,
                                          logic [KEY_W-1:0] listener,
                                          logic [DATA_W-1:0] payload);
        cache_cmd_t c;
        c.op       = op;
        c.owner    = owner;
        c.listener = listener;
        c.payload  = payload;
        return c;
    endfunction

    // driver: offers the head of cmd_q, predicts each command at its transfer
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic offer;
        if (!rst_n)
        begin
            start         <= 1'b0;
            opcode        <= '0;
            owner_key     <= '0;
            listener_key  <= '0;
            event_payload <= '0;
            idle_left     <= 0;
        end
        else
        begin
            offer = start;
            if (start && !busy)
            begin
                result_q.push_back(predict_cache_result(cur_cmd));
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (idle_left > 0)
                    idle_left <= idle_left - 1;
                else if (gaps_on && $urandom_range(0, 15) == 0)
                    idle_left <= $urandom_range(1, 10) - 1;
                else if (cmd_q.size() != 0)
                begin
                    cur_cmd        = cmd_q.pop_front();
                    opcode        <= cur_cmd.op;
                    owner_key     <= cur_cmd.owner;
                    listener_key  <= cur_cmd.listener;
                    event_payload <= cur_cmd.payload;
                    offer          = 1'b1;
                end
            end
            start <= offer;
        end
    end

    always @(posedge clk)
    begin : monitor
        cache_result_t want;
        if (rst_n && done)
        begin
            if (result_q.size() == 0)
            begin
                $error("unexpected result: status %0d, popped_payload %h, occupancy %0d",
                       status, popped_payload, occupancy);
                errors++;
            end
            else
            begin
                want = result_q.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    errors++;
                end
                if (popped_payload !== want.payload)
                begin
                    $error("popped_payload: expected %h, got %h", want.payload, popped_payload);
                    errors++;
                end
                if (occupancy !== want.occ)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
                    errors++;
                end
            end
        end
    end

    // ends the run when no transfer in either direction happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        cache_cmd_t       c;
        logic [REG_W-1:0] cfg_val;
        logic [KEY_W-1:0] owner_pool[3];
        logic [KEY_W-1:0] listener_pool[3];
        int               mode_left;
        int               init_due;
        int               roll;
        int               noise;
        bit               fill_mode;

        clear_table();
        is_ready      = 1'b0;
        none_listener = '0;
        mode_left     = 0;
        init_due      = 0;
        fill_mode     = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       cfg_val = '0;
                1:       cfg_val = '1;
                3:       cfg_val = '0;
                default: cfg_val = $urandom;
            endcase
            if (phase == PHASES - 1)
                gaps_on = 1'b0;

            // register write, then read it back
            @(posedge clk);
            psel    <= 1'b1;
            pwrite  <= 1'b1;
            penable <= 1'b0;
            paddr   <= {REG_NO_LISTENER, 2'b00};
            pwdata  <= cfg_val;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            none_listener = cfg_val;
            pwrite  <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata !== cfg_val)
            begin
                $error("prdata: expected %h, got %h", cfg_val, prdata);
                errors++;
            end
            psel    <= 1'b0;
            penable <= 1'b0;

            if (phase == 0)
            begin
                // not ready, then fill to capacity, full, oldest-first pop, rejects, no match, shutdown
                cmd_q.push_back(mk_cmd(OP_INSERT, '1, '1, '1));
                cmd_q.push_back(mk_cmd(OP_POP, '1, '1, '0));
                cmd_q.push_back(mk_cmd(OP_SHUTDOWN, '0, '0, '1));
                cmd_q.push_back(mk_cmd(OP_INIT, '1, '1, '0));
                for (int i = 0; i < DEPTH; i++)
                begin
                    c = mk_cmd(OP_INSERT, i[0] ? '1 : '0, i[1] ? '1 : 32'h1,
                               {$urandom, $urandom});
                    if (i == 0)
                        c.payload = '0;
                    else if (i == 1)
                        c.payload = '1;
                    cmd_q.push_back(c);
                end
                cmd_q.push_back(mk_cmd(OP_INSERT, 32'h5, 32'h5, '1));
                cmd_q.push_back(mk_cmd(OP_POP, '1, '1, '0));
                cmd_q.push_back(mk_cmd(OP_POP, '0, '0, '0));
                cmd_q.push_back(mk_cmd(OP_POP, 32'h1234, 32'h1, '0));
                cmd_q.push_back(mk_cmd(OP_SHUTDOWN, '1, '1, '1));
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    owner_pool[k]    = $urandom;
                    listener_pool[k] = $urandom;
                end
                owner_pool[2]    = phase[0] ? '1 : '0;
                listener_pool[2] = phase[0] ? '0 : '1;
                cmd_q.push_back(mk_cmd(OP_INIT, $urandom, $urandom, {$urandom, $urandom}));
                for (int n = 0; n < PER_PHASE; n++)
                begin
                    // alternate filling and draining stretches so the table hits full and empty
                    if (mode_left == 0)
                    begin
                        fill_mode = !fill_mode;
                        mode_left = $urandom_range(20, 60);
                    end
                    mode_left--;
                    roll       = $urandom_range(0, 99);
                    c.owner    = owner_pool[$urandom_range(0, 2)];
                    c.listener = listener_pool[$urandom_range(0, 2)];
                    c.payload  = {$urandom, $urandom};
                    if (init_due > 0)
                    begin
                        init_due--;
                        if (init_due == 0)
                            c.op = OP_INIT;
                        else
                            c.op = (roll < 50) ? OP_INSERT : OP_POP;
                    end
                    else if (roll < 2)
                    begin
                        c.op     = OP_SHUTDOWN;
                        init_due = $urandom_range(1, 4);
                    end
                    else if (roll < 3)
                        c.op = OP_INIT;
                    else if (roll < (fill_mode ? 75 : 30))
                        c.op = OP_INSERT;
                    else
                        c.op = OP_POP;
                    noise = $urandom_range(0, 99);
                    if (noise < 4)
                        c.owner = $urandom;
                    else if (noise < 8)
                        c.listener = $urandom;
                    else if (noise < 12 && c.op == OP_POP)
                        c.listener = none_listener;
                    cmd_q.push_back(c);
                end
            end

            while (cmd_q.size() != 0 || start || busy || result_q.size() != 0)
                @(posedge clk);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (result_q.size() != 0)
        begin
            $error("%0d results never arrived", result_q.size());
            errors++;
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/kofe_pkg.sv
design/kofe_cell.sv
design/kofe_ctrl.sv
design/keyed_oldest_first_event_cache_unit.sv
design/kofe_checker.sv
verif/keyed_oldest_first_event_cache_unit_tb.sv
